>>> hw/rtl/ksbl_pkg.sv
// shared types, constants and codes of the k-th successor core
`default_nettype none
package ksbl_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 60;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int LEVEL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int STEP_W    = 60;
  localparam int DATA_W    = 64;
  localparam int JT_AW     = LEVEL_W + NODE_W;
  localparam int JT_DEPTH  = 2 ** JT_AW;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 64;

  localparam logic [CNT_W-1:0]   MAX_NODES_C = CNT_W'(MAX_NODES);
  localparam logic [LEVEL_W-1:0] LAST_LEVEL  = LEVEL_W'(LEVELS - 1);

  // input functions
  localparam logic [1:0] FN_LD_PARENT = 2'd0;
  localparam logic [1:0] FN_LD_VALUE  = 2'd1;
  localparam logic [1:0] FN_BUILD     = 2'd2;
  localparam logic [1:0] FN_QUERY     = 2'd3;

  // result status
  localparam logic [1:0] ST_ANSWER = 2'd0;
  localparam logic [1:0] ST_BUILT  = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // register indexes
  localparam logic REG_STEP_COUNT = 1'b0;
  localparam logic REG_NODE_COUNT = 1'b1;

  // jump table address modes
  localparam logic [2:0] JA_REQ      = 3'd0;
  localparam logic [2:0] JA_PREV_VTX = 3'd1;
  localparam logic [2:0] JA_PREV_MID = 3'd2;
  localparam logic [2:0] JA_CUR_VTX  = 3'd3;
  localparam logic [2:0] JA_QUERY    = 3'd4;

  typedef struct packed {
    logic [1:0]               func;
    logic [NODE_W-1:0]        node;
    logic signed [DATA_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [NODE_W-1:0]        reached_node;
    logic signed [DATA_W-1:0] answer_value;
  } rsp_t;

  typedef struct packed {
    logic       capture_req;
    logic       jt_we;
    logic [2:0] jt_sel;
    logic       val_we;
    logic       lvl_clr;
    logic       lvl_one;
    logic       lvl_inc;
    logic       vtx_clr;
    logic       vtx_inc;
    logic       cur_load_req;
    logic       cur_load_rdata;
    logic       built_clr;
    logic       built_set;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_ok;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       node_oor;
    logic       parent_oor;
    logic       built;
    logic       bit_set;
    logic       lvl_last;
    logic       vtx_last;
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/ksbl_ram.sv
// generic single-port ram with registered read
`default_nettype none
module ksbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/ksbl_ctrl.sv
// controller state machine for load, build and query sequencing
`default_nettype none
module ksbl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire ksbl_pkg::sts_t sts,
  output ksbl_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_BRD1  = 4'd2;
  localparam logic [3:0] S_BRD2  = 4'd3;
  localparam logic [3:0] S_BWR   = 4'd4;
  localparam logic [3:0] S_QSTEP = 4'd5;
  localparam logic [3:0] S_QWAIT = 4'd6;
  localparam logic [3:0] S_QVAL  = 4'd7;
  localparam logic [3:0] S_QOUT  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.jt_sel = ksbl_pkg::JA_QUERY;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture_req = 1'b1;
          state_next      = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_IDLE;
        case (sts.func)
          ksbl_pkg::FN_LD_PARENT: begin
            if (sts.node_oor || sts.parent_oor) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ksbl_pkg::ST_RANGE;
            end else begin
              cmd.jt_we     = 1'b1;
              cmd.jt_sel    = ksbl_pkg::JA_REQ;
              cmd.built_clr = 1'b1;
            end
          end
          ksbl_pkg::FN_LD_VALUE: begin
            if (sts.node_oor) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ksbl_pkg::ST_RANGE;
            end else begin
              cmd.val_we = 1'b1;
            end
          end
          ksbl_pkg::FN_BUILD: begin
            if (ksbl_pkg::LEVELS == 1) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ksbl_pkg::ST_BUILT;
              cmd.built_set   = 1'b1;
            end else begin
              cmd.lvl_one = 1'b1;
              cmd.vtx_clr = 1'b1;
              state_next  = S_BRD1;
            end
          end
          default: begin
            if (sts.node_oor || !sts.built) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ksbl_pkg::ST_RANGE;
            end else begin
              cmd.cur_load_req = 1'b1;
              cmd.lvl_clr      = 1'b1;
              state_next       = S_QSTEP;
            end
          end
        endcase
      end
      S_BRD1: begin
        cmd.jt_sel = ksbl_pkg::JA_PREV_VTX;
        state_next = S_BRD2;
      end
      S_BRD2: begin
        cmd.jt_sel = ksbl_pkg::JA_PREV_MID;
        state_next = S_BWR;
      end
      S_BWR: begin
        cmd.jt_we  = 1'b1;
        cmd.jt_sel = ksbl_pkg::JA_CUR_VTX;
        state_next = S_BRD1;
        if (sts.vtx_last) begin
          cmd.vtx_clr = 1'b1;
          if (sts.lvl_last) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ksbl_pkg::ST_BUILT;
            cmd.built_set   = 1'b1;
            state_next      = S_IDLE;
          end else begin
            cmd.lvl_inc = 1'b1;
          end
        end else begin
          cmd.vtx_inc = 1'b1;
        end
      end
      S_QSTEP: begin
        cmd.jt_sel = ksbl_pkg::JA_QUERY;
        if (sts.bit_set) begin
          state_next = S_QWAIT;
        end else if (sts.lvl_last) begin
          state_next = S_QVAL;
        end else begin
          cmd.lvl_inc = 1'b1;
        end
      end
      S_QWAIT: begin
        cmd.cur_load_rdata = 1'b1;
        if (sts.lvl_last) begin
          state_next = S_QVAL;
        end else begin
          cmd.lvl_inc = 1'b1;
          state_next  = S_QSTEP;
        end
      end
      S_QVAL: begin
        state_next = S_QOUT;
      end
      S_QOUT: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = ksbl_pkg::ST_ANSWER;
        cmd.emit_ok     = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/ksbl_dp.sv
// datapath: registers, jump table and value memories, result register
`default_nettype none
module ksbl_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ksbl_pkg::req_t                req,
  input  wire ksbl_pkg::cmd_t                cmd,
  output ksbl_pkg::sts_t                     sts,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_idx,
  input  wire logic [ksbl_pkg::APB_DW-1:0]   cfg_data,
  output logic [ksbl_pkg::STEP_W-1:0]        step_count,
  output logic [ksbl_pkg::CNT_W-1:0]         node_count,
  output logic                               done,
  output ksbl_pkg::rsp_t                     rsp
);

  ksbl_pkg::req_t                    req_q;
  logic                              built;
  logic [ksbl_pkg::LEVEL_W-1:0]      lvl;
  logic [ksbl_pkg::LEVEL_W-1:0]      lvl_prev;
  logic [ksbl_pkg::NODE_W-1:0]       vtx;
  logic [ksbl_pkg::NODE_W-1:0]       cur;
  logic [ksbl_pkg::CNT_W-1:0]        cnt_wr;

  logic                              jt_we;
  logic [ksbl_pkg::JT_AW-1:0]        jt_addr;
  logic [ksbl_pkg::NODE_W-1:0]       jt_wdata;
  logic [ksbl_pkg::NODE_W-1:0]       jt_rdata;
  logic [ksbl_pkg::NODE_W-1:0]       val_addr;
  logic [ksbl_pkg::DATA_W-1:0]       val_rdata;

  assign lvl_prev = lvl - 1'b1;

  always_comb begin
    cnt_wr = cfg_data[ksbl_pkg::CNT_W-1:0];
    if (cnt_wr == '0) begin
      cnt_wr = ksbl_pkg::CNT_W'(1);
    end else if (cnt_wr > ksbl_pkg::MAX_NODES_C) begin
      cnt_wr = ksbl_pkg::MAX_NODES_C;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
      node_count <= ksbl_pkg::CNT_W'(1);
      built      <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == ksbl_pkg::REG_STEP_COUNT) begin
        step_count <= cfg_data[ksbl_pkg::STEP_W-1:0];
      end
      if (cfg_we && cfg_idx == ksbl_pkg::REG_NODE_COUNT) begin
        node_count <= cnt_wr;
        built      <= 1'b0;
      end else if (cmd.built_clr) begin
        built <= 1'b0;
      end else if (cmd.built_set) begin
        built <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_req) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl <= '0;
      vtx <= '0;
      cur <= '0;
    end else begin
      if (cmd.lvl_clr) begin
        lvl <= '0;
      end else if (cmd.lvl_one) begin
        lvl <= ksbl_pkg::LEVEL_W'(1);
      end else if (cmd.lvl_inc) begin
        lvl <= lvl + 1'b1;
      end
      if (cmd.vtx_clr) begin
        vtx <= '0;
      end else if (cmd.vtx_inc) begin
        vtx <= vtx + 1'b1;
      end
      if (cmd.cur_load_req) begin
        cur <= req_q.node;
      end else if (cmd.cur_load_rdata) begin
        cur <= jt_rdata;
      end
    end
  end

  // jump table address is {level, node}
  always_comb begin
    case (cmd.jt_sel)
      ksbl_pkg::JA_REQ:      jt_addr = {ksbl_pkg::LEVEL_W'(0), req_q.node};
      ksbl_pkg::JA_PREV_VTX: jt_addr = {lvl_prev, vtx};
      ksbl_pkg::JA_PREV_MID: jt_addr = {lvl_prev, jt_rdata};
      ksbl_pkg::JA_CUR_VTX:  jt_addr = {lvl, vtx};
      default:               jt_addr = {lvl, cur};
    endcase
  end

  assign jt_we    = cmd.jt_we;
  assign jt_wdata = (cmd.jt_sel == ksbl_pkg::JA_REQ) ?
                    req_q.payload[ksbl_pkg::NODE_W-1:0] : jt_rdata;
  assign val_addr = cmd.val_we ? req_q.node : cur;

  ksbl_ram #(
    .WIDTH (ksbl_pkg::NODE_W),
    .DEPTH (ksbl_pkg::JT_DEPTH)
  ) u_jump_table (
    .clk   (clk),
    .we    (jt_we),
    .addr  (jt_addr),
    .wdata (jt_wdata),
    .rdata (jt_rdata)
  );

  ksbl_ram #(
    .WIDTH (ksbl_pkg::DATA_W),
    .DEPTH (ksbl_pkg::MAX_NODES)
  ) u_node_values (
    .clk   (clk),
    .we    (cmd.val_we),
    .addr  (val_addr),
    .wdata (req_q.payload),
    .rdata (val_rdata)
  );

  always_comb begin
    sts.func       = req_q.func;
    sts.node_oor   = ({1'b0, req_q.node} >= node_count);
    sts.parent_oor = (req_q.payload[ksbl_pkg::DATA_W-1:ksbl_pkg::CNT_W] != '0) ||
                     (req_q.payload[ksbl_pkg::CNT_W-1:0] >= node_count);
    sts.built      = built;
    sts.bit_set    = step_count[lvl];
    sts.lvl_last   = (lvl == ksbl_pkg::LAST_LEVEL);
    sts.vtx_last   = ({1'b0, vtx} == node_count - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status       <= cmd.emit_status;
      rsp.reached_node <= cmd.emit_ok ? cur : '0;
      rsp.answer_value <= cmd.emit_ok ? val_rdata : '0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/kth_successor_binary_lifting_core.sv
// top level of the binary lifting k-th successor core
//
// usage: an item is taken when start is high and busy is low. func selects
// load parent, load value, build jump table or query. loads that succeed
// give no result; out-of-range loads, builds and queries give exactly one
// result beat, marked by done for one cycle, which the receiver must take.
// work per item after it is accepted:
//   loads: the dispatch state writes the entry or emits the error beat
//   build: for every level above 0 and every node, three dependent
//          accesses of the single jump table port
//   query: levels are walked in order, one table read per set bit of
//          step_count, then one node value read
// busy stays high until the result beat is loaded, so one item is in work
// at a time. registers are written over the apb port (step_count at 0,
// node_count at 8); the user must write them only while busy is low, which
// the core does not enforce. a node_count write or a stored parent marks
// the table unbuilt. reset clears control state and the registers
// (step_count 0, node_count 1); table and value memories are not cleared and must be loaded before use.
`default_nettype none
module kth_successor_binary_lifting_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire ksbl_pkg::req_t                req,
  output logic                               done,
  output ksbl_pkg::rsp_t                     rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ksbl_pkg::APB_AW-1:0]   paddr,
  input  wire logic [ksbl_pkg::APB_DW-1:0]   pwdata,
  output logic [ksbl_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  ksbl_pkg::cmd_t                  cmd;
  ksbl_pkg::sts_t                  sts;
  logic                            cfg_we;
  logic                            cfg_idx;
  logic [ksbl_pkg::STEP_W-1:0]     step_count;
  logic [ksbl_pkg::CNT_W-1:0]      node_count;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3];
  assign prdata  = (cfg_idx == ksbl_pkg::REG_NODE_COUNT) ?
                   ksbl_pkg::APB_DW'(node_count) : ksbl_pkg::APB_DW'(step_count);

  ksbl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ksbl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (pwdata),
    .step_count (step_count),
    .node_count (node_count),
    .done       (done),
    .rsp        (rsp)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beats back to back");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without an item in work");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ksbl_pkg::ST_ANSWER) |->
    (rsp.reached_node == '0 && rsp.answer_value == '0))
    else $error("non-answer beat carries nonzero fields");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ksbl_pkg::ST_ANSWER || rsp.status == ksbl_pkg::ST_BUILT ||
              rsp.status == ksbl_pkg::ST_RANGE))
    else $error("illegal result status");
`endif

endmodule
`default_nettype wire
